// ----- sv/u16d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package u16d_pkg;

    localparam int CP_W   = 21;
    localparam int UNIT_W = 16;
    localparam int BYTE_W = 8;
    localparam int HS_W   = 10;

    // result queue depth; two slots cover the worst request, two more absorb stalls
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [CP_W-1:0] CP_REPL      = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX_LEGAL = 21'h10FFFD;
    localparam logic [CP_W-1:0] CP_NC_LO     = 21'h00FDD0;
    localparam logic [CP_W-1:0] CP_NC_HI     = 21'h00FDEF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [15:0]     LO16_FFFE    = 16'hFFFE;

    // top six bits of a 16-bit unit
    localparam logic [5:0] TAG_HIGH_SURR = 6'b110110;
    localparam logic [5:0] TAG_LOW_SURR  = 6'b110111;

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_FLUSH = 1'b1
    } t_kind;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            last_of_run;
    } t_res;

    // up to two results produced by one request
    typedef struct packed {
        logic [1:0] count;
        t_res       r0;
        t_res       r1;
    } t_res_pair;

    function automatic logic f_legal(input logic [CP_W-1:0] cp);
        logic ok;
        ok = 1'b1;
        if (cp[15:1] == LO16_FFFE[15:1]) ok = 1'b0;       // FFFE or FFFF in low half
        if (cp > CP_MAX_LEGAL) ok = 1'b0;
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ok = 1'b0;
        if (cp >= CP_NC_LO && cp <= CP_NC_HI) ok = 1'b0;
        return ok;
    endfunction

    function automatic t_res f_checked(input logic [CP_W-1:0] cp, input logic last);
        t_res r;
        if (f_legal(cp)) begin
            r.code_point = cp;
            r.replaced   = 1'b0;
        end else begin
            r.code_point = CP_REPL;
            r.replaced   = 1'b1;
        end
        r.last_of_run = last;
        return r;
    endfunction

    function automatic t_res f_repl(input logic last);
        t_res r;
        r.code_point  = CP_REPL;
        r.replaced    = 1'b1;
        r.last_of_run = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/u16d_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u16d_decode
    import u16d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_big_endian,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire t_kind             i_kind,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [Q_CW-1:0]   i_q_free,
    output      t_res_pair         o_push
);

    // input register
    logic              r_in_valid;
    t_kind             r_in_kind;
    logic [BYTE_W-1:0] r_in_byte;

    // stream state
    logic              r_held_valid;
    logic [BYTE_W-1:0] r_held_byte;
    logic              r_hs_valid;
    logic [HS_W-1:0]   r_hs_bits;

    logic              n_held_valid;
    logic [BYTE_W-1:0] n_held_byte;
    logic              n_hs_valid;
    logic [HS_W-1:0]   n_hs_bits;

    logic [UNIT_W-1:0] unit;
    logic              is_high;
    logic              is_low;
    logic [CP_W-1:0]   joined;
    t_res_pair         pair;
    logic              adv;

    assign unit    = i_big_endian ? {r_held_byte, r_in_byte} : {r_in_byte, r_held_byte};
    assign is_high = (unit[15:10] == TAG_HIGH_SURR);
    assign is_low  = (unit[15:10] == TAG_LOW_SURR);
    assign joined  = CP_SUPP_BASE + CP_W'({r_hs_bits, unit[9:0]});

    always_comb begin
        pair         = '0;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        n_hs_valid   = r_hs_valid;
        n_hs_bits    = r_hs_bits;
        if (r_in_kind == KIND_FLUSH) begin
            // pending surrogate first, odd byte second
            pair.count   = 2'({1'b0, r_hs_valid}) + 2'({1'b0, r_held_valid});
            pair.r0      = f_repl(!(r_hs_valid && r_held_valid));
            pair.r1      = f_repl(1'b1);
            n_held_valid = 1'b0;
            n_hs_valid   = 1'b0;
        end else if (!r_held_valid) begin
            n_held_valid = 1'b1;
            n_held_byte  = r_in_byte;
        end else begin
            n_held_valid = 1'b0;
            if (r_hs_valid && is_low) begin
                pair.count = 2'd1;
                pair.r0    = f_checked(joined, 1'b1);
                n_hs_valid = 1'b0;
            end else if (r_hs_valid) begin
                // orphaned high surrogate, then the unit on its own unless it is itself a high surrogate
                pair.r0 = f_repl(is_high);
                pair.r1 = f_checked(CP_W'(unit), 1'b1);
                if (is_high) begin
                    pair.count = 2'd1;
                    n_hs_bits  = unit[HS_W-1:0];
                end else begin
                    pair.count = 2'd2;
                    n_hs_valid = 1'b0;
                end
            end else if (is_high) begin
                n_hs_valid = 1'b1;
                n_hs_bits  = unit[HS_W-1:0];
            end else begin
                pair.count = 2'd1;
                pair.r0    = f_checked(CP_W'(unit), 1'b1);
            end
        end
    end

    assign adv     = r_in_valid && (i_q_free >= Q_CW'(pair.count));
    assign o_ready = !r_in_valid || adv;

    always_comb begin
        o_push = pair;
        if (!adv) o_push.count = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_held_valid <= 1'b0;
            r_hs_valid   <= 1'b0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (adv) begin
                r_held_valid <= n_held_valid;
                r_hs_valid   <= n_hs_valid;
            end
        end
        if (o_ready && i_valid) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_byte;
        end
        if (adv) begin
            r_held_byte <= n_held_byte;
            r_hs_bits   <= n_hs_bits;
        end
    end

endmodule

`default_nettype wire

// ----- sv/u16d_rq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u16d_rq
    import u16d_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_res_pair       i_push,
    output      logic [Q_CW-1:0] o_free,
    output      logic            o_valid,
    input  wire logic            i_ready,
    output      t_res            o_res
);

    t_res              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr;
    logic [Q_AW-1:0]   r_rptr;
    logic [Q_CW-1:0]   r_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rptr];
    assign o_free  = Q_CW'(Q_DEPTH) - r_count;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + Q_AW'(i_push.count);
            r_rptr  <= r_rptr + Q_AW'(pop);
            r_count <= r_count + Q_CW'(i_push.count) - Q_CW'(pop);
        end
        if (i_push.count != 2'd0) r_mem[r_wptr] <= i_push.r0;
        if (i_push.count == 2'd2) r_mem[r_wptr + Q_AW'(1)] <= i_push.r1;
    end

endmodule

`default_nettype wire

// ----- sv/utf16_stream_decoder.sv -----
// Throughput: one input request per cycle while the result queue has room, and one
//   result per cycle while the receiver is ready; a request that makes two results
//   is absorbed by a 4-entry queue.
// Input is held off only while the result queue lacks room for the pending request.
// Reset: synchronous, active low; clears stream state and queue, big_endian returns to 1.
`timescale 1ns / 1ps
`default_nettype none

module utf16_stream_decoder
    import u16d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config: big_endian
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    // byte stream in
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] kind (1 = end of buffer flush)
    // code points out
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [23:0] o_m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output      logic        o_m_axis_tuser,   // [0] replaced
    output      logic        o_m_axis_tlast    // last_of_run
);

    logic            r_big_endian;
    logic [Q_CW-1:0] q_free;
    t_res_pair       push;
    t_res            res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b1;
        end else if (i_cfg_we) begin
            r_big_endian <= i_cfg_wdata;
        end
    end

    // input register, byte pairing, surrogate joining and legality check
    u16d_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_big_endian (r_big_endian),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_kind       (t_kind'(i_s_axis_tuser)),
        .i_byte       (i_s_axis_tdata),
        .i_q_free     (q_free),
        .o_push       (push)
    );

    // result queue: takes up to two results a cycle, hands out one
    u16d_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (q_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {3'b000, res.code_point};
    assign o_m_axis_tuser = res.replaced;
    assign o_m_axis_tlast = res.last_of_run;

endmodule

`default_nettype wire

// ----- sv/u16d_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u16d_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser,
    input wire logic        o_m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // replacement always carries U+FFFD
    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 24'h00FFFD)
        else $error("replaced result is not U+FFFD");

    // an unreplaced result is a legal scalar value
    a_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata <= 24'h10FFFD && o_m_axis_tdata[15:1] != 15'h7FFF
            && !(o_m_axis_tdata >= 24'h00D800 && o_m_axis_tdata <= 24'h00DFFF)
            && !(o_m_axis_tdata >= 24'h00FDD0 && o_m_axis_tdata <= 24'h00FDEF))
        else $error("illegal code point passed through");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind utf16_stream_decoder u16d_checker u_chk (.*);

`default_nettype wire

// ----- tb/tb_utf16_stream_decoder.sv -----
`timescale 1ns / 1ps

module tb_utf16_stream_decoder;
    import u16d_pkg::*;

    // ------------------------------------------------------------------
    // Expected-stream tracker: mirrors the decoder state (byte order, held
    // byte, pending high surrogate). It turns every accepted request into
    // the code points the block must emit, and checks emitted ones in order.
    // ------------------------------------------------------------------
    class code_point_tracker;
        bit         big_endian;
        logic [7:0] held_byte;
        bit         held_valid;
        logic [9:0] hs_bits;
        bit         hs_valid;
        t_res       pending_points[$];
        int         mismatches;

        function new();
            big_endian = 1'b1;
            held_byte  = '0;
            held_valid = 1'b0;
            hs_bits    = '0;
            hs_valid   = 1'b0;
            mismatches = 0;
        endfunction

        function automatic bit scalar_ok(logic [CP_W-1:0] cp);
            if (cp[15:0] == 16'hFFFE || cp[15:0] == 16'hFFFF) return 1'b0;
            if (cp > 21'h10FFFD) return 1'b0;
            if (cp >= 21'h00D800 && cp <= 21'h00DFFF) return 1'b0;
            if (cp >= 21'h00FDD0 && cp <= 21'h00FDEF) return 1'b0;
            return 1'b1;
        endfunction

        function automatic t_res scalar_result(logic [CP_W-1:0] cp);
            t_res r;
            r.last_of_run = 1'b0;
            r.replaced    = !scalar_ok(cp);
            r.code_point  = r.replaced ? CP_REPL : cp;
            return r;
        endfunction

        function automatic t_res repl_result();
            t_res r;
            r.code_point  = CP_REPL;
            r.replaced    = 1'b1;
            r.last_of_run = 1'b0;
            return r;
        endfunction

        function void note_request(t_kind kind, logic [7:0] data_byte);
            t_res        made [2];
            int          n;
            logic [15:0] unit;
            n = 0;
            if (kind == KIND_FLUSH) begin
                if (hs_valid) begin
                    made[n] = repl_result();
                    n++;
                end
                if (held_valid) begin
                    made[n] = repl_result();
                    n++;
                end
                hs_valid   = 1'b0;
                hs_bits    = '0;
                held_valid = 1'b0;
                held_byte  = '0;
            end else if (!held_valid) begin
                held_byte  = data_byte;
                held_valid = 1'b1;
            end else begin
                unit = big_endian ? {held_byte, data_byte} : {data_byte, held_byte};
                held_valid = 1'b0;
                held_byte  = '0;
                if (hs_valid && unit[15:10] == TAG_LOW_SURR) begin
                    // pair: 0x10000 + (high bits << 10) + low bits
                    made[n] = scalar_result(21'h010000 + {1'b0, hs_bits, unit[9:0]});
                    n++;
                    hs_valid = 1'b0;
                    hs_bits  = '0;
                end else begin
                    if (hs_valid) begin
                        made[n] = repl_result();
                        n++;
                        hs_valid = 1'b0;
                        hs_bits  = '0;
                    end
                    if (unit[15:10] == TAG_HIGH_SURR) begin
                        hs_bits  = unit[9:0];
                        hs_valid = 1'b1;
                    end else begin
                        made[n] = scalar_result({5'd0, unit});
                        n++;
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                made[i].last_of_run = (i == n - 1);
                pending_points.push_back(made[i]);
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t ns: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [23:0] data, logic replaced, logic last);
            t_res want;
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected result cp=%06h rep=%0b last=%0b",
                                 data, replaced, last));
                return;
            end
            want = pending_points.pop_front();
            if (data !== {3'b000, want.code_point})
                report($sformatf("code point %06h, want %06h", data, want.code_point));
            if (replaced !== want.replaced)
                report($sformatf("replaced %0b, want %0b (cp %06h)",
                                 replaced, want.replaced, want.code_point));
            if (last !== want.last_of_run)
                report($sformatf("last %0b, want %0b (cp %06h)",
                                 last, want.last_of_run, want.code_point));
        endtask

        function int outstanding();
            return pending_points.size();
        endfunction

        task close_out();
            if (pending_points.size() != 0)
                report($sformatf("%0d results never arrived", pending_points.size()));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_wdata     = 1'b1;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata  = 8'h00;
    logic        i_s_axis_tuser  = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    localparam int HOLD_CYCLES = 60;

    code_point_tracker sb = new;

    // stimulus knobs, changed between phases
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit cur_be        = 1'b1;   // byte order the generator writes units in
    int bytes_sent    = 0;      // data bytes only; flushes don't count
    logic sink_hold   = 1'b0;   // long receiver hold-off for back-pressure

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    utf16_stream_decoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] data_byte
        .i_s_axis_tuser  (i_s_axis_tuser),   // [0] kind
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [20:0] code_point, [23:21] zero
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] replaced
        .o_m_axis_tlast  (o_m_axis_tlast)    // last_of_run
    );

    // Receiver: random ready, forced low during a hold-off stretch.
    always @(posedge i_clk) begin
        i_m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    // Monitor: all sampling at the rising edge sees pre-edge values, since
    // both the DUT and the drivers update through nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.big_endian = i_cfg_wdata;
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_request(t_kind'(i_s_axis_tuser), i_s_axis_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One request; returns at the edge where it is taken. tvalid stays up
    // afterwards so back-to-back requests need no gap.
    task automatic send_request(input t_kind kind, input logic [7:0] data_byte);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= data_byte;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (kind == KIND_DATA)
            bytes_sent++;
    endtask

    // A 16-bit unit as two bytes in the current byte order.
    task automatic send_unit(input logic [15:0] unit);
        if (cur_be) begin
            send_request(KIND_DATA, unit[15:8]);
            send_request(KIND_DATA, unit[7:0]);
        end else begin
            send_request(KIND_DATA, unit[7:0]);
            send_request(KIND_DATA, unit[15:8]);
        end
    endtask

    // Stop offering, wait for every expected result, then cover the pipeline
    // latency so a request with no result is fully retired too.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Byte order change, only with the block idle.
    task automatic write_byte_order(input bit be);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= be;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_be = be;
    endtask

    // Mostly well-formed UTF-16 with random content; some broken pieces and noise.
    task automatic run_random(input int n_bytes);
        int          pick;
        int          plane;
        logic [15:0] hi_unit;
        int          target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_unit(16'($urandom));
            end else if (pick < 55) begin
                // proper surrogate pair
                send_unit({TAG_HIGH_SURR, 10'($urandom)});
                send_unit({TAG_LOW_SURR, 10'($urandom)});
            end else if (pick < 67) begin
                case ($urandom_range(5))
                    0: send_unit({15'h7FFF, 1'($urandom)});           // FFFE / FFFF
                    1: send_unit(16'hFDD0 + 16'($urandom_range(31))); // noncharacters
                    2: send_unit({8'hFD, 8'($urandom)});              // around them
                    3: send_unit($urandom_range(1) ? 16'hFFFD : 16'h0000);
                    4: begin
                        // top of the code space, some above 10FFFD
                        send_unit(16'hDBFF);
                        send_unit({TAG_LOW_SURR, 4'hF, 6'($urandom)});
                    end
                    default: begin
                        // plane-end noncharacters xFFFE / xFFFF
                        plane   = $urandom_range(16, 1);
                        hi_unit = {TAG_HIGH_SURR, 4'(plane - 1), 6'h3F};
                        send_unit(hi_unit);
                        send_unit({TAG_LOW_SURR, 9'h1FF, 1'($urandom)});
                    end
                endcase
            end else if (pick < 75) begin
                send_unit({TAG_HIGH_SURR, 10'($urandom)});       // may be left alone
            end else if (pick < 82) begin
                send_unit({TAG_LOW_SURR, 10'($urandom)});        // lone low
            end else if (pick < 88) begin
                send_request(KIND_FLUSH, 8'($urandom));
            end else if (pick < 94) begin
                // truncated unit, usually closed by an end of buffer
                send_request(KIND_DATA, 8'($urandom));
                if ($urandom_range(9) < 7)
                    send_request(KIND_FLUSH, 8'($urandom));
            end else begin
                send_request(KIND_DATA, 8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset byte order (big endian), special cases
        sink_idle_pct = 30;
        send_unit(16'h0041);                                   // plain BMP
        send_unit(16'hFFFE);                                   // low half FFFE
        send_unit(16'hFDD0);                                   // noncharacter
        send_unit(16'hD800); send_unit(16'hDC00);              // first supplementary
        send_unit(16'hDBFF); send_unit(16'hDFFF);              // 10FFFF, illegal
        send_unit(16'hDC00);                                   // lone low
        send_unit(16'hD800); send_unit(16'h0041);              // high then non-low
        send_unit(16'hD800);                                   // high, odd byte, flush
        send_request(KIND_DATA, 8'h34);
        send_request(KIND_FLUSH, 8'hFF);
        send_request(KIND_FLUSH, 8'h00);                       // nothing pending

        // phase 1: little endian, slow receiver
        write_byte_order(1'b0);
        src_idle_pct  = 7;
        sink_idle_pct = 81;
        run_random(300);

        // phase 2: big endian, slow sender
        write_byte_order(1'b1);
        src_idle_pct  = 81;
        sink_idle_pct = 7;
        run_random(300);

        // phase 3: no idling; a long receiver hold-off first so the result
        // queue fills and the input side stalls
        write_byte_order(1'b0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        join_none
        run_random(200);
        write_byte_order(1'b1);
        run_random(200);

        drain_results();
        repeat (6) @(posedge i_clk);
        sb.close_out();
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
